>>> rtl/core/wfc_pkg.sv
package wfc_pkg;

    localparam int KEY_SLOTS_DEF = 4;
    localparam int KEY_BYTES_DEF = 16;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_BODY  = 2'd2;

    localparam logic [1:0] STAT_DATA    = 2'd0;
    localparam logic [1:0] STAT_ICV_OK  = 2'd1;
    localparam logic [1:0] STAT_ICV_BAD = 2'd2;

    localparam logic       CFG_TX_KEY_ID   = 1'b0;
    localparam logic       CFG_KEY_LENGTHS = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_KSA,
        ST_KS,
        ST_DATA,
        ST_ICV_KS,
        ST_ICV_OUT,
        ST_STAT
    } t_state;

    typedef enum logic [3:0] {
        R_IDLE,
        R_INIT,
        R_K1,
        R_K2,
        R_K3,
        R_K4,
        R_G2,
        R_G3,
        R_G4,
        R_G5,
        R_G6
    } t_rc4_state;

    typedef enum logic [1:0] {
        KSEL_IV,
        KSEL_KEY,
        KSEL_ZERO
    } t_ksel;

    typedef struct packed {
        logic        key_we;
        logic [1:0]  key_slot;
        logic [3:0]  key_idx;
        logic [7:0]  key_data;
        logic        ksa_start;
        logic [23:0] iv;
        logic [1:0]  slot;
        logic [4:0]  len;
        logic        ks_req;
    } t_rc4_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] ks;
    } t_rc4_rsp;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/wfc_ram.sv
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wfc_rc4.sv
module wfc_rc4 #(
    parameter int KEY_SLOTS = wfc_pkg::KEY_SLOTS_DEF,
    parameter int KEY_BYTES = wfc_pkg::KEY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfc_pkg::t_rc4_req i_req,
    output wfc_pkg::t_rc4_rsp o_rsp
);
    import wfc_pkg::*;

    localparam int KDEPTH = KEY_SLOTS * KEY_BYTES;
    localparam int KAW    = $clog2(KDEPTH);

    t_rc4_state r_st, n_st;
    logic [7:0]  r_k, n_k;
    logic [7:0]  r_i, n_i;
    logic [7:0]  r_j, n_j;
    logic [4:0]  r_m, n_m;
    logic [7:0]  r_si, n_si;
    logic [7:0]  r_sj, n_sj;
    logic [23:0] r_iv, n_iv;
    logic [1:0]  r_slot, n_slot;
    logic [4:0]  r_len, n_len;
    logic [4:0]  r_total, n_total;
    t_ksel       r_ksel, n_ksel;
    logic [KDEPTH-1:0] r_kvalid;

    logic       s_we;
    logic [7:0] s_waddr, s_wdata, s_raddr, s_rdata;
    logic [KAW-1:0] k_waddr, k_raddr;
    logic [7:0] k_rdata;
    logic       k_we;
    logic [4:0] w_kidx;
    logic [4:0] w_sum;
    logic [7:0] w_kb;
    logic [7:0] w_jn;

    assign k_we    = i_req.key_we && (32'(i_req.key_slot) < KEY_SLOTS)
                     && (32'(i_req.key_idx) < KEY_BYTES);
    assign k_waddr = KAW'(32'(i_req.key_slot) * KEY_BYTES + 32'(i_req.key_idx));
    assign w_kidx  = r_m - 5'd3;
    assign k_raddr = KAW'(32'(r_slot) * KEY_BYTES + 32'(w_kidx));
    assign w_sum   = i_req.len + 5'd10;

    wfc_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    wfc_ram #(.WIDTH(8), .DEPTH(KDEPTH)) u_keys (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (i_req.key_data),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    always_comb begin
        case (r_ksel)
            KSEL_IV:  w_kb = r_iv[8*r_m[1:0] +: 8];
            KSEL_KEY: w_kb = k_rdata;
            default:  w_kb = 8'd0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            R_IDLE: begin
                if (i_req.ksa_start) begin
                    n_st = R_INIT;
                end else if (i_req.ks_req) begin
                    n_st = R_G2;
                end
            end
            R_INIT:  if (r_k == 8'hff) n_st = R_K1;
            R_K1:    n_st = R_K2;
            R_K2:    n_st = R_K3;
            R_K3:    n_st = R_K4;
            R_K4:    n_st = (r_k == 8'hff) ? R_IDLE : R_K1;
            R_G2:    n_st = R_G3;
            R_G3:    n_st = R_G4;
            R_G4:    n_st = R_G5;
            R_G5:    n_st = R_G6;
            R_G6:    n_st = R_IDLE;
            default: n_st = R_IDLE;
        endcase
    end

    always_comb begin
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        n_si    = r_si;
        n_sj    = r_sj;
        n_iv    = r_iv;
        n_slot  = r_slot;
        n_len   = r_len;
        n_total = r_total;
        n_ksel  = r_ksel;
        s_we    = 1'b0;
        s_waddr = r_k;
        s_wdata = r_k;
        s_raddr = r_k;
        w_jn    = r_j + s_rdata;
        o_rsp.busy = (r_st != R_IDLE);
        o_rsp.done = 1'b0;
        o_rsp.ks   = s_rdata;
        case (r_st)
            R_IDLE: begin
                if (i_req.ksa_start) begin
                    n_iv    = i_req.iv;
                    n_slot  = i_req.slot;
                    n_len   = i_req.len;
                    n_total = {w_sum[4:3], 3'b000};
                    n_k     = 8'd0;
                end else if (i_req.ks_req) begin
                    n_i     = r_i + 8'd1;
                    s_raddr = r_i + 8'd1;
                end
            end
            R_INIT: begin
                s_we = 1'b1;
                n_k  = r_k + 8'd1;
                n_j  = 8'd0;
                n_m  = 5'd0;
            end
            R_K1: begin
                if (r_m < 5'd3) begin
                    n_ksel = KSEL_IV;
                end else if ((w_kidx < r_len) && (32'(r_slot) < KEY_SLOTS)
                             && r_kvalid[k_raddr]) begin
                    n_ksel = KSEL_KEY;
                end else begin
                    n_ksel = KSEL_ZERO;
                end
            end
            R_K2: begin
                w_jn    = r_j + s_rdata + w_kb;
                n_j     = w_jn;
                n_si    = s_rdata;
                s_raddr = w_jn;
            end
            R_K3: begin
                s_we    = 1'b1;
                s_wdata = s_rdata;
            end
            R_K4: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_si;
                n_k     = r_k + 8'd1;
                n_m     = (r_m + 5'd1 == r_total) ? 5'd0 : r_m + 5'd1;
                if (r_k == 8'hff) begin
                    o_rsp.done = 1'b1;
                    n_i = 8'd0;
                    n_j = 8'd0;
                end
            end
            R_G2: begin
                n_si    = s_rdata;
                n_j     = w_jn;
                s_raddr = w_jn;
            end
            R_G3: begin
                s_we    = 1'b1;
                s_waddr = r_i;
                s_wdata = s_rdata;
                n_sj    = s_rdata;
            end
            R_G4: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_si;
            end
            R_G5: begin
                s_raddr = r_si + r_sj;
            end
            R_G6: begin
                o_rsp.done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= R_IDLE;
            r_i      <= 8'd0;
            r_j      <= 8'd0;
            r_kvalid <= '0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
            r_j  <= n_j;
            if (k_we) begin
                r_kvalid[k_waddr] <= 1'b1;
            end
        end
        r_k     <= n_k;
        r_m     <= n_m;
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_iv    <= n_iv;
        r_slot  <= n_slot;
        r_len   <= n_len;
        r_total <= n_total;
        r_ksel  <= n_ksel;
    end

endmodule

>>> rtl/core/wep_frame_crypt.sv
// Channel | Dir | Handshake                 | Payload
// in      | in  | i_in_valid / o_in_ready   | i_cmd i_transmit i_key_slot i_key_byte_index
//         |     |                           | i_data_byte i_last_byte i_random_iv
// out     | out | o_out_valid / i_out_ready | o_out_byte o_out_last o_status
// cfg     | in  | i_cfg_we                  | i_cfg_index i_cfg_data
//
// Key load: a single input transfer. Transmit start: 4 header transfers, then the
// sbox fill and the key schedule (4 sbox RAM accesses per step).
// Body byte: keystream generation on the sbox RAM, then the byte is emitted;
// a transmit last byte adds 4 ICV bytes, each with its own keystream. Receive 4th
// header byte runs the sbox fill and key schedule. Sync active-low reset; the output
// register lets the next item in while a result waits for i_out_ready.
module wep_frame_crypt #(
    parameter int KEY_SLOTS = wfc_pkg::KEY_SLOTS_DEF,
    parameter int KEY_BYTES = wfc_pkg::KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic        i_transmit,
    input  logic [1:0]  i_key_slot,
    input  logic [3:0]  i_key_byte_index,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_random_iv,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import wfc_pkg::*;

    t_state r_state, n_state;
    logic        r_active, n_active;
    logic        r_dir, n_dir;
    logic [2:0]  r_bc, n_bc;
    logic        r_hold_full, n_hold_full;
    logic [7:0]  r_hold [4];
    logic [7:0]  n_hold [4];
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_ivc, n_ivc;
    logic [23:0] r_iv, n_iv;
    logic [1:0]  r_fkey, n_fkey;
    logic [7:0]  r_d, n_d;
    logic        r_last, n_last;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_ks;
    logic [31:0] r_icv, n_icv;
    logic [1:0]  r_tx_key_id;
    logic [19:0] r_key_lengths;
    logic        r_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic [1:0]  r_status, n_status;
    logic        w_load;

    t_rc4_req w_req;
    t_rc4_rsp w_rsp;

    logic        w_acc, w_free;
    logic [31:0] w_iv_pick, w_iv;
    logic [1:0]  w_ksa_slot;
    logic [4:0]  w_len_raw;
    logic [7:0]  w_dx;
    logic [31:0] w_crc_tx, w_crc_rx;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_free     = !r_out_valid || i_out_ready;
    assign w_dx       = r_d ^ r_ks;
    assign w_crc_tx   = crc_byte(r_crc, r_d);
    assign w_crc_rx   = crc_byte(r_crc, r_hold[0]);

    assign w_iv_pick = (r_ivc != 32'd0) ? r_ivc : i_random_iv;
    assign w_iv = ((w_iv_pick >= 32'h0003ff00)
                   && ((w_iv_pick & 32'h00f8ff00) == 32'h0000ff00))
                  ? w_iv_pick + 32'h00000100 : w_iv_pick;

    assign w_ksa_slot = (r_state == ST_HDR) ? r_fkey : i_data_byte[7:6];
    assign w_len_raw  = r_key_lengths[5*w_ksa_slot +: 5];

    wfc_rc4 #(.KEY_SLOTS(KEY_SLOTS), .KEY_BYTES(KEY_BYTES)) u_rc4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_cmd == CMD_START && i_transmit) begin
                    n_state = ST_HDR;
                end else if (w_acc && i_cmd == CMD_BODY && r_active) begin
                    if (r_dir || r_bc[2]) begin
                        n_state = ST_KS;
                    end else if (r_bc == 3'd3) begin
                        n_state = ST_KSA;
                    end else if (i_last_byte) begin
                        n_state = ST_STAT;
                    end
                end
            end
            ST_HDR: begin
                if (w_free && r_cnt == 2'd3) n_state = ST_KSA;
            end
            ST_KSA: begin
                if (w_rsp.done) n_state = (!r_dir && r_last) ? ST_STAT : ST_IDLE;
            end
            ST_KS: begin
                if (w_rsp.done) n_state = ST_DATA;
            end
            ST_DATA: begin
                if (r_dir) begin
                    if (w_free) n_state = r_last ? ST_ICV_KS : ST_IDLE;
                end else if (w_free || !r_hold_full) begin
                    n_state = r_last ? ST_STAT : ST_IDLE;
                end
            end
            ST_ICV_KS: begin
                if (w_rsp.done) n_state = ST_ICV_OUT;
            end
            ST_ICV_OUT: begin
                if (w_free) n_state = (r_cnt == 2'd3) ? ST_IDLE : ST_ICV_KS;
            end
            ST_STAT: begin
                if (w_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_dir       = r_dir;
        n_bc        = r_bc;
        n_hold_full = r_hold_full;
        n_hold      = r_hold;
        n_crc       = r_crc;
        n_ivc       = r_ivc;
        n_iv        = r_iv;
        n_fkey      = r_fkey;
        n_d         = r_d;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_icv       = r_icv;
        w_load      = 1'b0;
        n_out_byte  = 8'd0;
        n_out_last  = 1'b0;
        n_status    = STAT_DATA;

        w_req.key_we    = w_acc && (i_cmd == CMD_KEY);
        w_req.key_slot  = i_key_slot;
        w_req.key_idx   = i_key_byte_index;
        w_req.key_data  = i_data_byte;
        w_req.ksa_start = 1'b0;
        w_req.iv        = (r_state == ST_HDR) ? r_iv
                          : {r_hold[2], r_hold[1], r_hold[0]};
        w_req.slot      = w_ksa_slot;
        w_req.len       = (32'(w_len_raw) > KEY_BYTES) ? 5'(KEY_BYTES) : w_len_raw;
        w_req.ks_req    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_cmd == CMD_START) begin
                    n_active    = 1'b1;
                    n_dir       = i_transmit;
                    n_bc        = 3'd0;
                    n_hold_full = 1'b0;
                    n_hold      = '{default: 8'd0};
                    n_crc       = '1;
                    n_cnt       = 2'd0;
                    if (i_transmit) begin
                        n_ivc  = w_iv + 32'd1;
                        n_iv   = w_iv[23:0];
                        n_fkey = r_tx_key_id;
                    end
                end else if (w_acc && i_cmd == CMD_BODY && r_active) begin
                    n_d    = i_data_byte;
                    n_last = i_last_byte;
                    if (i_last_byte) n_active = 1'b0;
                    if (r_dir || r_bc[2]) begin
                        w_req.ks_req = 1'b1;
                    end else begin
                        n_bc = r_bc + 3'd1;
                        if (r_bc == 3'd3) begin
                            n_fkey          = i_data_byte[7:6];
                            w_req.ksa_start = 1'b1;
                            n_hold          = '{default: 8'd0};
                        end else begin
                            n_hold[r_bc[1:0]] = i_data_byte;
                        end
                    end
                end
            end
            ST_HDR: begin
                if (w_free) begin
                    w_load     = 1'b1;
                    n_out_byte = (r_cnt == 2'd3) ? {r_fkey, 6'd0} : r_iv[8*r_cnt +: 8];
                    n_cnt      = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) w_req.ksa_start = 1'b1;
                end
            end
            ST_DATA: begin
                if (r_dir) begin
                    if (w_free) begin
                        w_load     = 1'b1;
                        n_out_byte = w_dx;
                        n_crc      = w_crc_tx;
                        n_icv      = ~w_crc_tx;
                        n_cnt      = 2'd0;
                        if (r_last) w_req.ks_req = 1'b1;
                    end
                end else if (r_hold_full) begin
                    if (w_free) begin
                        w_load     = 1'b1;
                        n_out_byte = r_hold[0];
                        n_crc      = w_crc_rx;
                        n_hold[0]  = r_hold[1];
                        n_hold[1]  = r_hold[2];
                        n_hold[2]  = r_hold[3];
                        n_hold[3]  = w_dx;
                    end
                end else begin
                    n_hold[r_bc[1:0]] = w_dx;
                    if (r_bc == 3'd7) begin
                        n_hold_full = 1'b1;
                    end else begin
                        n_bc = r_bc + 3'd1;
                    end
                end
            end
            ST_ICV_OUT: begin
                if (w_free) begin
                    w_load     = 1'b1;
                    n_out_byte = r_icv[8*r_cnt +: 8] ^ r_ks;
                    n_out_last = (r_cnt == 2'd3);
                    n_cnt      = r_cnt + 2'd1;
                    if (r_cnt != 2'd3) w_req.ks_req = 1'b1;
                end
            end
            ST_STAT: begin
                if (w_free) begin
                    w_load     = 1'b1;
                    n_out_last = 1'b1;
                    n_status   = (r_hold_full && ({r_hold[3], r_hold[2], r_hold[1],
                                  r_hold[0]} == ~r_crc)) ? STAT_ICV_OK : STAT_ICV_BAD;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_active      <= 1'b0;
            r_dir         <= 1'b0;
            r_bc          <= 3'd0;
            r_hold_full   <= 1'b0;
            r_ivc         <= 32'd0;
            r_fkey        <= 2'd0;
            r_tx_key_id   <= 2'd0;
            r_key_lengths <= 20'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_dir       <= n_dir;
            r_bc        <= n_bc;
            r_hold_full <= n_hold_full;
            r_ivc       <= n_ivc;
            r_fkey      <= n_fkey;
            if (i_cfg_we && i_cfg_index == CFG_TX_KEY_ID) r_tx_key_id <= i_cfg_data[1:0];
            if (i_cfg_we && i_cfg_index == CFG_KEY_LENGTHS) r_key_lengths <= i_cfg_data;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_hold <= n_hold;
        r_crc  <= n_crc;
        r_iv   <= n_iv;
        r_d    <= n_d;
        r_last <= n_last;
        r_cnt  <= n_cnt;
        r_icv  <= n_icv;
        if (w_rsp.done) r_ks <= w_rsp.ks;
        if (w_load) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_status    = r_status;

`ifndef NO_ASSERTIONS
    a_ready_engine_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_rsp.busy)
        else $error("input ready while rc4 engine busy");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_KSA || r_state == ST_KS || r_state == ST_ICV_KS))
        else $error("rc4 engine finished with no waiting request");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_DATA) |-> (o_out_last && o_out_byte == 8'd0))
        else $error("status result not marked last");
`endif

endmodule
